/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Types and constants shared by the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;
  localparam int QuatW  = 16;
  localparam int RemW   = 33;
  localparam int Lanes  = 9;
  localparam int EntryW = 16;

  typedef struct packed {
    logic valid;
    logic zero;
  } qrm_ctl_t;

  typedef logic [Lanes-1:0][RemW-1:0]   rem_vec_t;
  typedef logic [Lanes-1:0][EntryW-1:0] entry_vec_t;
endpackage

/* rtl/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Fixed-point quaternion to normalized 3x3 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// One quaternion beat is taken every cycle; busy_o stays low. Each result
// beat appears on valid_o exactly FRAC_BITS + 6 cycles after its start_i beat
// (three front stages, one divider stage per quotient bit, one rounding stage)
// and must be taken in that cycle. Results come out in input order.
`include "assert_macros.svh"
module quaternion_to_rotation_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] quat_w_i,
  input  logic [15:0] quat_x_i,
  input  logic [15:0] quat_y_i,
  input  logic [15:0] quat_z_i,
  output logic        valid_o,
  output logic [15:0] m00_o,
  output logic [15:0] m01_o,
  output logic [15:0] m02_o,
  output logic [15:0] m10_o,
  output logic [15:0] m11_o,
  output logic [15:0] m12_o,
  output logic [15:0] m20_o,
  output logic [15:0] m21_o,
  output logic [15:0] m22_o,
  output logic        zero_norm_o
);
  localparam int QW     = FRAC_BITS + 2;
  localparam int NSTG   = QW;
  localparam int OneLim = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);

  qrm_pkg::qrm_ctl_t        ctl_s [NSTG+1];
  logic [qrm_pkg::RemW-1:0] n_s   [NSTG+1];
  qrm_pkg::rem_vec_t        rem_s [NSTG+1];
  logic [8:0][QW-1:0]       quo_s [NSTG+1];
  logic [8:0]               neg_s [NSTG+1];
  qrm_pkg::qrm_ctl_t        ctl_out;
  qrm_pkg::entry_vec_t      m;

  assign busy_o = 1'b0;

  qrm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i && !busy_o),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .ctl_o    (ctl_s[0]),
    .n_o      (n_s[0]),
    .mag_o    (rem_s[0]),
    .neg_o    (neg_s[0])
  );

  assign quo_s[0] = '0;

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    qrm_div_stage #(
      .QW    (QW),
      .FIRST (k == 0)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[k]),
      .n_i    (n_s[k]),
      .rem_i  (rem_s[k]),
      .quo_i  (quo_s[k]),
      .neg_i  (neg_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .n_o    (n_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .quo_o  (quo_s[k+1]),
      .neg_o  (neg_s[k+1])
    );
  end

  qrm_encode #(
    .FRAC_BITS (FRAC_BITS)
  ) u_encode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_s[NSTG]),
    .quo_i  (quo_s[NSTG]),
    .neg_i  (neg_s[NSTG]),
    .ctl_o  (ctl_out),
    .m_o    (m)
  );

  assign valid_o     = ctl_out.valid;
  assign zero_norm_o = ctl_out.zero;
  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

  `ASSERT_IMPLY(a_zero_identity, clk_i, rst_ni, valid_o && zero_norm_o, m00_o == 16'(OneLim) && m01_o == '0 && m22_o == 16'(OneLim), "zero quaternion did not give identity")
  `ASSERT_IMPLY(a_m00_range, clk_i, rst_ni, valid_o, $signed(m00_o) <= OneLim && $signed(m00_o) >= -OneLim - 1, "m00 out of range")
  `ASSERT_IMPLY(a_m12_range, clk_i, rst_ni, valid_o, $signed(m12_o) <= OneLim && $signed(m12_o) >= -OneLim - 1, "m12 out of range")
endmodule

/* rtl/qrm_front.sv */
// ----------------------------------------------------------------------------
// qrm_front
// Input register, product stage and sum stage: squared norm, nine numerators
// split into sign and magnitude.
// ----------------------------------------------------------------------------
module qrm_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [15:0]              quat_w_i,
  input  logic [15:0]              quat_x_i,
  input  logic [15:0]              quat_y_i,
  input  logic [15:0]              quat_z_i,
  output qrm_pkg::qrm_ctl_t        ctl_o,
  output logic [qrm_pkg::RemW-1:0] n_o,
  output qrm_pkg::rem_vec_t        mag_o,
  output logic [8:0]               neg_o
);
  logic               vld_a_q, vld_b_q;
  logic signed [15:0] w_q, x_q, y_q, z_q;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [35:0] sn, num [9];
  logic [qrm_pkg::RemW-1:0] n_d;
  qrm_pkg::rem_vec_t  mag_d;
  logic [8:0]         neg_d;
  qrm_pkg::qrm_ctl_t  ctl_q;
  logic [qrm_pkg::RemW-1:0] n_q;
  qrm_pkg::rem_vec_t  mag_q;
  logic [8:0]         neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      vld_a_q     <= valid_i;
      vld_b_q     <= vld_a_q;
      ctl_q.valid <= vld_b_q;
      ctl_q.zero  <= (n_d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= quat_w_i;
    x_q  <= quat_x_i;
    y_q  <= quat_y_i;
    z_q  <= quat_z_i;
    ww_q <= w_q * w_q;
    xx_q <= x_q * x_q;
    yy_q <= y_q * y_q;
    zz_q <= z_q * z_q;
    xy_q <= x_q * y_q;
    xz_q <= x_q * z_q;
    yz_q <= y_q * z_q;
    wx_q <= w_q * x_q;
    wy_q <= w_q * y_q;
    wz_q <= w_q * z_q;
    n_q   <= n_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  always_comb begin
    sn = 36'(ww_q) + 36'(xx_q) + 36'(yy_q) + 36'(zz_q);
    n_d = sn[qrm_pkg::RemW-1:0];
    num[0] = sn - 36'(2) * (36'(yy_q) + 36'(zz_q));
    num[1] = 36'(2) * (36'(xy_q) + 36'(wz_q));
    num[2] = 36'(2) * (36'(xz_q) - 36'(wy_q));
    num[3] = 36'(2) * (36'(xy_q) - 36'(wz_q));
    num[4] = sn - 36'(2) * (36'(xx_q) + 36'(zz_q));
    num[5] = 36'(2) * (36'(yz_q) + 36'(wx_q));
    num[6] = 36'(2) * (36'(xz_q) + 36'(wy_q));
    num[7] = 36'(2) * (36'(yz_q) - 36'(wx_q));
    num[8] = sn - 36'(2) * (36'(xx_q) + 36'(yy_q));
    for (int i = 0; i < 9; i++) begin
      neg_d[i] = num[i][35];
      mag_d[i] = neg_d[i] ? 33'(-num[i]) : num[i][qrm_pkg::RemW-1:0];
    end
  end

  assign ctl_o = ctl_q;
  assign n_o   = n_q;
  assign mag_o = mag_q;
  assign neg_o = neg_q;
endmodule

/* rtl/qrm_div_stage.sv */
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine lanes: one quotient bit per lane.
// ----------------------------------------------------------------------------
module qrm_div_stage #(
  parameter int QW    = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qrm_pkg::qrm_ctl_t        ctl_i,
  input  logic [qrm_pkg::RemW-1:0] n_i,
  input  qrm_pkg::rem_vec_t        rem_i,
  input  logic [8:0][QW-1:0]       quo_i,
  input  logic [8:0]               neg_i,
  output qrm_pkg::qrm_ctl_t        ctl_o,
  output logic [qrm_pkg::RemW-1:0] n_o,
  output qrm_pkg::rem_vec_t        rem_o,
  output logic [8:0][QW-1:0]       quo_o,
  output logic [8:0]               neg_o
);
  logic [qrm_pkg::RemW:0]   t [9];
  logic [qrm_pkg::RemW:0]   diff [9];
  qrm_pkg::rem_vec_t        rem_d;
  logic [8:0][QW-1:0]       quo_d;
  qrm_pkg::qrm_ctl_t        ctl_q;
  logic [qrm_pkg::RemW-1:0] n_q;
  qrm_pkg::rem_vec_t        rem_q;
  logic [8:0][QW-1:0]       quo_q;
  logic [8:0]               neg_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      t[i]    = FIRST ? {1'b0, rem_i[i]} : {rem_i[i], 1'b0};
      diff[i] = t[i] - {1'b0, n_i};
      if (t[i] >= {1'b0, n_i}) begin
        rem_d[i] = diff[i][qrm_pkg::RemW-1:0];
        quo_d[i] = {quo_i[i][QW-2:0], 1'b1};
      end else begin
        rem_d[i] = t[i][qrm_pkg::RemW-1:0];
        quo_d[i] = {quo_i[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_i;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_i;
  end

  assign ctl_o = ctl_q;
  assign n_o   = n_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign neg_o = neg_q;
endmodule

/* rtl/qrm_encode.sv */
// ----------------------------------------------------------------------------
// qrm_encode
// Rounds each quotient to nearest, clamps to [-1,1], applies the sign and
// substitutes the identity matrix for a zero quaternion.
// ----------------------------------------------------------------------------
module qrm_encode #(
  parameter int FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qrm_pkg::qrm_ctl_t            ctl_i,
  input  logic [8:0][FRAC_BITS+1:0]    quo_i,
  input  logic [8:0]                   neg_i,
  output qrm_pkg::qrm_ctl_t            ctl_o,
  output qrm_pkg::entry_vec_t          m_o
);
  localparam int QW = FRAC_BITS + 2;
  localparam int EW = (QW > 17) ? QW : 17;
  localparam logic [EW-1:0] One    = EW'(1) << FRAC_BITS;
  localparam logic [EW-1:0] NegMax = EW'(32768);
  localparam logic [EW-1:0] PosMax = EW'(32767);
  localparam logic [15:0]   Diag   = (One > PosMax) ? 16'(PosMax) : One[15:0];

  logic [EW-1:0]       q [9];
  qrm_pkg::entry_vec_t m_d;
  qrm_pkg::qrm_ctl_t   ctl_q;
  qrm_pkg::entry_vec_t m_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      q[i] = (EW'(quo_i[i]) + EW'(1)) >> 1;
      if (q[i] > One) q[i] = One;
      if (neg_i[i]) begin
        if (q[i] > NegMax) q[i] = NegMax;
        m_d[i] = 16'(-q[i]);
      end else begin
        if (q[i] > PosMax) q[i] = PosMax;
        m_d[i] = q[i][15:0];
      end
      if (ctl_i.zero) begin
        m_d[i] = (i == 0 || i == 4 || i == 8) ? Diag : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
  end

  assign ctl_o = ctl_q;
  assign m_o   = m_q;
endmodule
